// ===== rtl/rspl_pkg.sv =====
// ----------------------------------------------------------------------------
// rspl_pkg
// Shared types, widths and constants for the retry schedule parser/lookup.
// ----------------------------------------------------------------------------
package rspl_pkg;

  // Table geometry
  localparam int MaxEntries = 16;
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW       = $clog2(MaxEntries + 1);

  // Queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Field widths
  localparam int ActW     = 2;
  localparam int CharW    = 8;
  localparam int RcW      = 16;
  localparam int StatusW  = 4;
  localparam int IvalW    = 32;
  localparam int EntW     = 5;
  localparam int InDataW  = 24;
  localparam int OutDataW = 48;
  localparam int OutPadW  = OutDataW - (StatusW + 1 + IvalW + EntW);
  localparam int NumW     = 33;
  localparam int RepW     = 17;
  localparam int LimW     = 16;
  localparam int MulW     = 17;
  localparam int RamW     = LimW + IvalW;

  // Seconds per unit and the largest number that still fits in 32 bits
  localparam longint unsigned U32Max = 64'hFFFF_FFFF;
  localparam int SecPerDay  = 24 * 60 * 60;
  localparam int SecPerHour = 60 * 60;
  localparam int SecPerMin  = 60;
  localparam logic [NumW-1:0] DayLimit  = NumW'(U32Max / SecPerDay);
  localparam logic [NumW-1:0] HourLimit = NumW'(U32Max / SecPerHour);
  localparam logic [NumW-1:0] MinLimit  = NumW'(U32Max / SecPerMin);
  localparam logic [NumW-1:0] SecLimit  = NumW'(U32Max);

  localparam logic [NumW-1:0] NumSat = 33'h1_0000_0000;
  localparam logic [RepW-1:0] RepSat = 17'h1_0000;
  localparam logic [RepW-1:0] RepMax = 17'h0_FFFF;

  // Character codes
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChColon = 8'h3A;
  localparam logic [CharW-1:0] ChStar  = 8'h2A;
  localparam logic [CharW-1:0] ChComma = 8'h2C;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowD  = 8'h64;
  localparam logic [CharW-1:0] ChUpD   = 8'h44;
  localparam logic [CharW-1:0] ChLowH  = 8'h68;
  localparam logic [CharW-1:0] ChUpH   = 8'h48;
  localparam logic [CharW-1:0] ChLowM  = 8'h6D;
  localparam logic [CharW-1:0] ChUpM   = 8'h4D;
  localparam logic [CharW-1:0] ChLowS  = 8'h73;
  localparam logic [CharW-1:0] ChUpS   = 8'h53;

  typedef enum logic [ActW-1:0] {
    ACT_START = 2'd0,
    ACT_CHAR  = 2'd1,
    ACT_END   = 2'd2,
    ACT_QUERY = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    CC_DIGIT,
    CC_SPACE,
    CC_COLON,
    CC_STAR,
    CC_COMMA,
    CC_DAY,
    CC_HOUR,
    CC_MIN,
    CC_SEC,
    CC_OTHER
  } char_class_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_LEAD,
    PH_ITEM,
    PH_NUM,
    PH_AFTER_VAL,
    PH_COLON,
    PH_REP,
    PH_AFTER_REP,
    PH_DEAD
  } parse_phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 4'd0,
    ST_SUFFIX   = 4'd1,
    ST_COUNT    = 4'd2,
    ST_ZERO     = 4'd3,
    ST_BIGCOUNT = 4'd4,
    ST_TOTAL    = 4'd5,
    ST_CHAR     = 4'd6,
    ST_EMPTY    = 4'd7,
    ST_FULL     = 4'd8,
    ST_OVERFLOW = 4'd9,
    ST_DEAD     = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_QREAD,
    BK_QCMP
  } back_state_e;

  // One classified item as it waits in the queue
  typedef struct packed {
    action_e          act;
    char_class_e      cls;
    logic [CharW-1:0] chr;
    logic [RcW-1:0]   rc;
  } item_t;

endpackage

// ===== rtl/rspl_ram.sv =====
// ----------------------------------------------------------------------------
// rspl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rspl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rspl_front.sv =====
// ----------------------------------------------------------------------------
// rspl_front
// Accepts input transfers, classifies the byte and queues the item.
// ----------------------------------------------------------------------------
module rspl_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rspl_pkg::InDataW-1:0] s_axis_tdata_i,
  input  logic [rspl_pkg::ActW-1:0]    s_axis_tuser_i,
  output logic                         deq_valid_o,
  input  logic                         deq_ready_i,
  output rspl_pkg::item_t              deq_item_o
);
  import rspl_pkg::*;

  function automatic char_class_e classify(input logic [CharW-1:0] chr);
    char_class_e cls;
    case (chr) inside
      [ChZero:ChNine]: cls = CC_DIGIT;
      ChSpace:         cls = CC_SPACE;
      ChColon:         cls = CC_COLON;
      ChStar:          cls = CC_STAR;
      ChComma:         cls = CC_COMMA;
      ChLowD, ChUpD:   cls = CC_DAY;
      ChLowH, ChUpH:   cls = CC_HOUR;
      ChLowM, ChUpM:   cls = CC_MIN;
      ChLowS, ChUpS:   cls = CC_SEC;
      default:         cls = CC_OTHER;
    endcase
    return cls;
  endfunction

  item_t            mem_q [QueueDepth];
  item_t            in_item;
  logic [QPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             push, pop;

  always_comb begin
    in_item.act = action_e'(s_axis_tuser_i);
    in_item.chr = s_axis_tdata_i[CharW-1:0];
    in_item.rc  = s_axis_tdata_i[CharW +: RcW];
    in_item.cls = classify(s_axis_tdata_i[CharW-1:0]);
  end

  assign s_axis_tready_o = (cnt_q != QCntW'(QueueDepth));
  assign deq_valid_o     = (cnt_q != '0);
  assign deq_item_o      = mem_q[rptr_q];
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = deq_valid_o && deq_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_item;
    end
  end

endmodule

// ===== rtl/rspl_back.sv =====
// ----------------------------------------------------------------------------
// rspl_back
// Runs the parser one byte per cycle, save during a query walk or a stall,
// walks the table for queries and holds the result in the output register.
// ----------------------------------------------------------------------------
module rspl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          deq_valid_i,
  output logic                          deq_ready_o,
  input  rspl_pkg::item_t               deq_item_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [rspl_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rspl_pkg::*;

  back_state_e      state_q, state_d;
  parse_phase_e     phase_q, phase_s;
  logic [NumW-1:0]  num_q, num_s;
  logic [IvalW-1:0] ival_q, ival_s;
  logic [RepW-1:0]  rep_q, rep_s;
  logic [RepW-1:0]  total_q, total_s;
  logic [CntW-1:0]  used_q, used_s;
  logic             tval_q, tval_s;
  status_e          st_s;

  logic [IdxW-1:0]  qidx_q, qidx_d;
  logic [RcW-1:0]   rc_q;

  logic             out_free, take, step_en, fast_miss, hit, last;
  logic             wr_en, close_req, fail_req, start_byte;
  status_e          fail_code, close_code;
  logic [RepW-1:0]  close_sum;
  logic [3:0]       digit;
  logic [NumW+3:0]  num_x10;
  logic [RepW+3:0]  rep_x10;
  logic [MulW-1:0]  mult;
  logic [NumW-1:0]  mult_lim;
  logic [IvalW+MulW-1:0] prod;
  logic [RamW-1:0]  rdata;

  logic               m_valid_q;
  logic [OutDataW-1:0] m_data_q, m_data_d;
  logic               out_load;

  // Table: limit in the upper bits, interval in the lower bits
  rspl_ram #(
    .Width (RamW),
    .Depth (MaxEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (used_q[IdxW-1:0]),
    .wdata_i ({close_sum[LimW-1:0], ival_q}),
    .raddr_i (qidx_q),
    .rdata_o (rdata)
  );

  assign out_free    = !m_valid_q || m_axis_tready_i;
  assign deq_ready_o = (state_q == BK_IDLE) && out_free;
  assign take        = deq_valid_i && deq_ready_o;
  assign step_en     = take && (deq_item_i.act != ACT_QUERY);
  assign fast_miss   = !tval_q || (used_q == '0);
  assign hit         = rc_q < rdata[IvalW +: LimW];
  assign last        = (CntW'(qidx_q) + CntW'(1)) == used_q;

  // Arithmetic helpers
  assign digit     = deq_item_i.chr[3:0];
  assign num_x10   = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1) + (NumW+4)'(digit);
  assign rep_x10   = ({4'b0, rep_q} << 3) + ({4'b0, rep_q} << 1) + (RepW+4)'(digit);
  assign close_sum = total_q + rep_q;
  assign prod      = {{MulW{1'b0}}, num_q[IvalW-1:0]} * {{IvalW{1'b0}}, mult};

  always_comb begin
    case (deq_item_i.cls)
      CC_DAY: begin
        mult     = MulW'(SecPerDay);
        mult_lim = DayLimit;
      end
      CC_HOUR: begin
        mult     = MulW'(SecPerHour);
        mult_lim = HourLimit;
      end
      CC_MIN: begin
        mult     = MulW'(SecPerMin);
        mult_lim = MinLimit;
      end
      default: begin
        mult     = MulW'(1);
        mult_lim = SecLimit;
      end
    endcase
  end

  always_comb begin
    if (rep_q == '0) begin
      close_code = ST_ZERO;
    end else if (rep_q > RepMax) begin
      close_code = ST_BIGCOUNT;
    end else if (close_sum > RepMax) begin
      close_code = ST_TOTAL;
    end else if (used_q >= CntW'(MaxEntries)) begin
      close_code = ST_FULL;
    end else begin
      close_code = ST_OK;
    end
  end

  // Parser step for start, byte and end items
  always_comb begin
    phase_s    = phase_q;
    num_s      = num_q;
    ival_s     = ival_q;
    rep_s      = rep_q;
    total_s    = total_q;
    used_s     = used_q;
    tval_s     = tval_q;
    st_s       = ST_OK;
    wr_en      = 1'b0;
    close_req  = 1'b0;
    fail_req   = 1'b0;
    fail_code  = ST_OK;
    start_byte = 1'b0;

    case (deq_item_i.act)
      ACT_START: begin
        tval_s  = 1'b0;
        used_s  = '0;
        total_s = '0;
        num_s   = '0;
        ival_s  = '0;
        rep_s   = RepW'(1);
        phase_s = PH_LEAD;
      end
      ACT_CHAR: begin
        case (phase_q)
          PH_LEAD: begin
            start_byte = (deq_item_i.cls != CC_SPACE);
          end
          PH_ITEM: begin
            start_byte = 1'b1;
          end
          PH_NUM: begin
            if (deq_item_i.cls == CC_DIGIT) begin
              num_s = (num_x10 > (NumW+4)'(NumSat)) ? NumSat : num_x10[NumW-1:0];
            end else if (deq_item_i.cls inside {CC_DAY, CC_HOUR, CC_MIN, CC_SEC}) begin
              if (num_q > mult_lim) begin
                fail_req  = 1'b1;
                fail_code = ST_OVERFLOW;
              end else begin
                ival_s  = prod[IvalW-1:0];
                phase_s = PH_AFTER_VAL;
              end
            end else begin
              fail_req  = 1'b1;
              fail_code = ST_SUFFIX;
            end
          end
          PH_AFTER_VAL: begin
            case (deq_item_i.cls)
              CC_SPACE: ;
              CC_COLON: phase_s = PH_COLON;
              CC_COMMA: begin
                phase_s   = PH_ITEM;
                close_req = 1'b1;
              end
              default: begin
                fail_req  = 1'b1;
                fail_code = ST_CHAR;
              end
            endcase
          end
          PH_COLON: begin
            case (deq_item_i.cls)
              CC_SPACE: ;
              CC_STAR: begin
                rep_s   = RepMax - total_q;
                phase_s = PH_AFTER_REP;
              end
              CC_DIGIT: begin
                rep_s   = RepW'(digit);
                phase_s = PH_REP;
              end
              default: begin
                fail_req  = 1'b1;
                fail_code = ST_COUNT;
              end
            endcase
          end
          PH_REP, PH_AFTER_REP: begin
            if (phase_q == PH_REP && deq_item_i.cls == CC_DIGIT) begin
              rep_s = (rep_x10 > (RepW+4)'(RepSat)) ? RepSat : rep_x10[RepW-1:0];
            end else begin
              phase_s = PH_AFTER_REP;
              case (deq_item_i.cls)
                CC_SPACE: ;
                CC_COMMA: begin
                  phase_s   = PH_ITEM;
                  close_req = 1'b1;
                end
                default: begin
                  fail_req  = 1'b1;
                  fail_code = ST_CHAR;
                end
              endcase
            end
          end
          default: st_s = ST_DEAD;
        endcase

        // First byte of an item
        if (start_byte) begin
          case (deq_item_i.cls)
            CC_SPACE: phase_s = PH_ITEM;
            CC_DIGIT: begin
              num_s   = NumW'(digit);
              phase_s = PH_NUM;
            end
            CC_COLON: phase_s = PH_COLON;
            CC_COMMA: begin
              phase_s   = PH_ITEM;
              close_req = 1'b1;
            end
            default: begin
              fail_req  = 1'b1;
              fail_code = ST_CHAR;
            end
          endcase
        end
      end
      ACT_END: begin
        case (phase_q)
          PH_LEAD: begin
            tval_s  = 1'b1;
            phase_s = PH_IDLE;
          end
          PH_ITEM: begin
            fail_req  = 1'b1;
            fail_code = ST_EMPTY;
          end
          PH_NUM: begin
            fail_req  = 1'b1;
            fail_code = ST_CHAR;
          end
          PH_COLON: begin
            fail_req  = 1'b1;
            fail_code = ST_COUNT;
          end
          PH_AFTER_VAL, PH_REP, PH_AFTER_REP: begin
            close_req = 1'b1;
            tval_s    = 1'b1;
            phase_s   = PH_IDLE;
          end
          default: st_s = ST_DEAD;
        endcase
      end
      default: ;
    endcase

    // Close the item: append one table entry, or fail with the close status
    if (close_req) begin
      if (close_code != ST_OK) begin
        fail_req  = 1'b1;
        fail_code = close_code;
      end else begin
        total_s = close_sum;
        wr_en   = step_en;
        used_s  = used_q + CntW'(1);
        num_s   = '0;
        ival_s  = '0;
        rep_s   = RepW'(1);
      end
    end

    // Any error drops the table and kills the parse
    if (fail_req) begin
      tval_s  = 1'b0;
      used_s  = '0;
      total_s = '0;
      phase_s = PH_DEAD;
      st_s    = fail_code;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (take && deq_item_i.act == ACT_QUERY && !fast_miss) begin
          state_d = BK_QREAD;
        end
      end
      BK_QREAD: state_d = BK_QCMP;
      BK_QCMP: begin
        if (hit || last) begin
          if (out_free) begin
            state_d = BK_IDLE;
          end
        end else begin
          state_d = BK_QREAD;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Walk index and result register load
  always_comb begin
    qidx_d   = qidx_q;
    out_load = 1'b0;
    m_data_d = m_data_q;
    case (state_q)
      BK_IDLE: begin
        qidx_d = '0;
        if (step_en) begin
          out_load = 1'b1;
          m_data_d = {{OutPadW{1'b0}}, (tval_s ? EntW'(used_s) : EntW'(0)),
                      {IvalW{1'b0}}, 1'b0, st_s};
        end else if (take && fast_miss) begin
          out_load = 1'b1;
          m_data_d = {{OutPadW{1'b0}}, (tval_q ? EntW'(used_q) : EntW'(0)),
                      {IvalW{1'b0}}, 1'b0, ST_OK};
        end
      end
      BK_QCMP: begin
        if (hit || last) begin
          if (out_free) begin
            out_load = 1'b1;
            m_data_d = {{OutPadW{1'b0}}, EntW'(used_q),
                        (hit ? rdata[IvalW-1:0] : {IvalW{1'b0}}), hit, ST_OK};
          end
        end else begin
          qidx_d = qidx_q + IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      phase_q   <= PH_IDLE;
      num_q     <= '0;
      ival_q    <= '0;
      rep_q     <= RepW'(1);
      total_q   <= '0;
      used_q    <= '0;
      tval_q    <= 1'b0;
      qidx_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      qidx_q  <= qidx_d;
      if (step_en) begin
        phase_q <= phase_s;
        num_q   <= num_s;
        ival_q  <= ival_s;
        rep_q   <= rep_s;
        total_q <= total_s;
        used_q  <= used_s;
        tval_q  <= tval_s;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rc_q <= deq_item_i.rc;
    end
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

// ===== rtl/retry_schedule_parse_lookup_top.sv =====
// ----------------------------------------------------------------------------
// retry_schedule_parse_lookup_top
// Retry schedule string parser with attempt-limit table and query lookup.
// ----------------------------------------------------------------------------
// Every input transfer gives exactly one output transfer, in order. A start
// clears the table and opens a parse; schedule bytes ("30s:3, 5m:*" style,
// comma-separated items, optional d/h/m/s number and ':' count or '*') are
// parsed at one byte per cycle in the back end when no query walk is busy
// and the result register is free; an end closes the table. A query walks
// the stored entries from the first and returns the interval of the first
// one whose cumulative limit exceeds the retry count. A query is answered
// without a table walk when the table is invalid or empty; otherwise it
// examines up to 16 entries in turn, each with one registered read of the
// table RAM (BK_QREAD) and one compare (BK_QCMP). A two-entry queue sits
// between the input side and the back end, and the result sits in an
// output register, so input transfers keep landing while a result waits
// to be taken. Any parse error drops the table; bytes or an end with no
// open parse report the dead status and change nothing.
// ----------------------------------------------------------------------------
module retry_schedule_parse_lookup_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: [7:0] char_code, [23:8] retry_count
  input  logic [rspl_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: [1:0] action
  input  logic [rspl_pkg::ActW-1:0]     s_axis_tuser_i,
  // Result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata: [3:0] status, [4] retry_allowed, [36:5] interval_seconds,
  //        [41:37] entry_count, [47:42] zero
  output logic [rspl_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rspl_pkg::*;

  // Classified items waiting for the back end
  logic  deq_valid;
  logic  deq_ready;
  item_t deq_item;

  // Front: accept the transfer, classify the byte, queue the item
  rspl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .deq_valid_o     (deq_valid),
    .deq_ready_i     (deq_ready),
    .deq_item_o      (deq_item)
  );

  // Back: advance the parser, walk the table, hold the result
  rspl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .deq_valid_i     (deq_valid),
    .deq_ready_o     (deq_ready),
    .deq_item_i      (deq_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== rtl/rspl_checker.sv =====
// ----------------------------------------------------------------------------
// rspl_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rspl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [rspl_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import rspl_pkg::*;

  logic [StatusW-1:0] status;
  logic               allowed;
  logic [IvalW-1:0]   interval;
  logic [EntW-1:0]    count;

  assign status   = m_axis_tdata_o[StatusW-1:0];
  assign allowed  = m_axis_tdata_o[StatusW];
  assign interval = m_axis_tdata_o[StatusW+1 +: IvalW];
  assign count    = m_axis_tdata_o[StatusW+1+IvalW +: EntW];

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> status <= ST_DEAD)
    else $error("status code out of range");

  a_allowed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && allowed |-> status == ST_OK)
    else $error("retry allowed with error status");

  a_no_retry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !allowed |-> interval == '0)
    else $error("interval set without a retry");

  // A parse error always drops the table
  a_error_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && status != ST_OK && status != ST_DEAD |-> count == '0)
    else $error("table left valid after an error");

endmodule

bind retry_schedule_parse_lookup_top rspl_checker u_rspl_checker (.*);
